### sv/tcf_pkg.sv
`timescale 1ns / 1ps

package tcf_pkg;

	// CORDIC datapath: accelerometer values scaled by 2^16 and grown by the
	// CORDIC gain over two chained passes stay well below 2^35.
	localparam int CW_W = 36;
	typedef logic signed [CW_W-1:0] cw_t;

	// Q16.16 angles and Q2.30 CORDIC angles share one 32-bit signed type.
	typedef logic signed [31:0] ang_t;

	// Accumulator of the digit-serial multiplier; the widest product is
	// (rate * ticks) * gyro_gain, which needs 65 bits.
	localparam int ACC_W = 68;
	typedef logic signed [ACC_W-1:0] acc_t;

	// Multiplier digit width and digit counter.
	localparam int DIGIT_W = 4;
	typedef logic [3:0] dig_cnt_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef struct packed {
		logic     go;
		logic     keep;
		dig_cnt_t digits;
	} mac_cmd_t;

	// Configuration register indexes.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_GYRO_GAIN = 2'd0;
	localparam reg_idx_t REG_TILT_GAIN = 2'd1;
	localparam reg_idx_t REG_BLEND     = 2'd2;

	localparam logic [31:0] GYRO_GAIN_RST = 32'd0;
	localparam logic [23:0] TILT_GAIN_RST = 24'd3754936;
	localparam logic [15:0] BLEND_RST     = 16'd64880;

	// Truncated atan(2^-s) in Q2.30 radians.
	function automatic ang_t atan_q30(input logic [4:0] s);
		ang_t r;
		case (s)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### sv/tcf_in_if.sv
`timescale 1ns / 1ps

interface tcf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	logic        [15:0] elapsed_ticks;

	modport source (
		output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ticks,
		input  ready
	);
	modport sink (
		input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ticks,
		output ready
	);
endinterface

### sv/tcf_out_if.sv
`timescale 1ns / 1ps

interface tcf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] roll_angle;
	logic signed [31:0] pitch_angle;
	logic signed [31:0] yaw_angle;

	modport source (
		output valid, roll_angle, pitch_angle, yaw_angle,
		input  ready
	);
	modport sink (
		input  valid, roll_angle, pitch_angle, yaw_angle,
		output ready
	);
endinterface

### sv/tcf_cordic.sv
`timescale 1ns / 1ps

// Vectoring CORDIC, one micro-rotation per cycle. The x input must be
// non-negative. Shifts are arithmetic, so they round toward minus infinity.
module tcf_cordic import tcf_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  cw_t        x_in,
	input  cw_t        y_in,
	output cw_t        x_out,
	output ang_t       z_out,
	output unit_stat_t stat
);

	localparam int CNT_W = $clog2(STEPS);

	logic [CNT_W-1:0] i_q;
	logic             busy_q;
	logic             done_q;
	cw_t              x_q;
	cw_t              y_q;
	ang_t             z_q;

	logic [4:0] sh;
	cw_t        dx;
	cw_t        dy;
	ang_t       da;

	always_comb begin
		sh = 5'(i_q);
		dx = y_q >>> sh;
		dy = x_q >>> sh;
		da = atan_q30(sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (i_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[CW_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end
		end
	end

	assign x_out     = x_q;
	assign z_out     = z_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### sv/tcf_mac.sv
`timescale 1ns / 1ps

// Digit-serial multiply-accumulate: the unsigned multiplier is consumed four
// bits a cycle, least significant digit first, against a signed multiplicand.
module tcf_mac import tcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mac_cmd_t    cmd,
	input  acc_t        acc_init,
	input  acc_t        mcand,
	input  logic [31:0] mplier,
	output acc_t        acc,
	output unit_stat_t  stat
);

	dig_cnt_t    cnt_q;
	logic        done_q;
	acc_t        acc_q;
	acc_t        a_q;
	logic [31:0] b_q;
	acc_t        part;

	assign part = ACC_W'(a_q * $signed({1'b0, b_q[DIGIT_W-1:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				cnt_q <= cmd.digits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dig_cnt_t'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			if (!cmd.keep) begin
				acc_q <= acc_init;
			end
			a_q <= mcand;
			b_q <= mplier;
		end else if (cnt_q != '0) begin
			acc_q <= acc_q + part;
			a_q   <= a_q <<< DIGIT_W;
			b_q   <= b_q >> DIGIT_W;
		end
	end

	assign acc       = acc_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

### sv/tilt_complementary_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// in_ch     sink       valid / ready  accel_x/y/z, rate_x/y/z, elapsed_ticks
// out_ch    source     valid / ready  roll_angle, pitch_angle, yaw_angle
// cfg       write      cfg_we         cfg_index, cfg_data
//
// One item is worked on at a time. Up to six CORDIC passes, one rotation a
// cycle, and fourteen digit-serial multiplies, four multiplier bits a cycle,
// run one after the other.
// Reset clears the kept angles and loads the register defaults.
// A new item is taken as soon as the previous one has been worked through,
// even while its result still waits in the output register; the finished
// result then waits for the output register to be free.
module tilt_complementary_filter import tcf_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tcf_in_if.sink      in_ch,
	tcf_out_if.source   out_ch,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CPASS,
		ST_CWAIT,
		ST_MPASS,
		ST_MWAIT,
		ST_OUT
	} state_t;

	// The six CORDIC passes: for each of roll and pitch, the magnitude of
	// the two other axes, the gain-matched single axis, and the angle.
	typedef enum logic [2:0] {
		PASS_MAG_R,
		PASS_ONE_R,
		PASS_ANG_R,
		PASS_MAG_P,
		PASS_ONE_P,
		PASS_ANG_P
	} pass_t;

	// Multiplies: the two tilt scalings, then per axis rate*ticks, the
	// gyro gain, and the two halves of the blend.
	typedef enum logic [2:0] {
		OP_TILT_R,
		OP_TILT_P,
		OP_RT,
		OP_PG,
		OP_BK,
		OP_BT
	} mac_op_t;

	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	localparam acc_t TILT_ROUND  = acc_t'(1) <<< 29;
	localparam acc_t BLEND_ROUND = acc_t'(32768);

	// |v| scaled by 2^16, and v scaled by 2^16.
	function automatic cw_t abs_scaled(input logic signed [15:0] v);
		cw_t m;
		m = cw_t'(v);
		if (v[15]) begin
			m = -m;
		end
		return m <<< 16;
	endfunction

	function automatic cw_t scaled(input logic signed [15:0] v);
		return cw_t'(v) <<< 16;
	endfunction

	function automatic ang_t sat32(input acc_t v);
		ang_t r;
		if (v > acc_t'(32'sh7FFFFFFF)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -(acc_t'(1) <<< 31)) begin
			r = 32'sh80000000;
		end else begin
			r = ang_t'(v);
		end
		return r;
	endfunction

	// Configuration registers.
	logic [31:0] gyro_gain_q;
	logic [23:0] tilt_gain_q;
	logic [15:0] blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q <= GYRO_GAIN_RST;
			tilt_gain_q <= TILT_GAIN_RST;
			blend_q     <= BLEND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GYRO_GAIN: gyro_gain_q <= cfg_data;
				REG_TILT_GAIN: tilt_gain_q <= cfg_data[23:0];
				REG_BLEND:     blend_q     <= cfg_data[15:0];
				default:       ;
			endcase
		end
	end

	state_t             state_q;
	pass_t              pass_q;
	mac_op_t            op_q;
	logic [1:0]         axis_q;
	logic signed [15:0] ax_q;
	logic signed [15:0] ay_q;
	logic signed [15:0] az_q;
	logic signed [15:0] rate_q [3];
	logic        [15:0] ticks_q;
	cw_t                m_q;
	cw_t                s_q;
	ang_t               zr_q;
	ang_t               zp_q;
	ang_t               tilt_q [2];
	acc_t               prod_q;
	ang_t               sum_q;
	ang_t               angle_q [3];
	ang_t               res_q [3];
	ang_t               out_q [3];
	logic               out_valid_q;

	// Unit command registers.
	logic               cordic_go_q;
	cw_t                cx_q;
	cw_t                cy_q;
	mac_cmd_t           mac_cmd_q;
	acc_t               mac_init_q;
	acc_t               mac_a_q;
	logic [31:0]        mac_b_q;

	cw_t                c_x;
	ang_t               c_z;
	unit_stat_t         c_stat;
	acc_t               m_acc;
	unit_stat_t         m_stat;

	tcf_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cordic_go_q),
		.x_in   (cx_q),
		.y_in   (cy_q),
		.x_out  (c_x),
		.z_out  (c_z),
		.stat   (c_stat)
	);

	tcf_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mac_cmd_q),
		.acc_init (mac_init_q),
		.mcand    (mac_a_q),
		.mplier   (mac_b_q),
		.acc      (m_acc),
		.stat     (m_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_MAG_R;
			op_q        <= OP_TILT_R;
			axis_q      <= AXIS_ROLL;
			ax_q        <= '0;
			ay_q        <= '0;
			az_q        <= '0;
			rate_q      <= '{default: '0};
			ticks_q     <= '0;
			m_q         <= '0;
			s_q         <= '0;
			zr_q        <= '0;
			zp_q        <= '0;
			tilt_q      <= '{default: '0};
			prod_q      <= '0;
			sum_q       <= '0;
			angle_q     <= '{default: '0};
			res_q       <= '{default: '0};
			out_q       <= '{default: '0};
			out_valid_q <= 1'b0;
			cordic_go_q <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			mac_cmd_q   <= '0;
			mac_init_q  <= '0;
			mac_a_q     <= '0;
			mac_b_q     <= '0;
		end else begin
			cordic_go_q  <= 1'b0;
			mac_cmd_q.go <= 1'b0;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						ax_q      <= in_ch.accel_x;
						ay_q      <= in_ch.accel_y;
						az_q      <= in_ch.accel_z;
						rate_q[0] <= in_ch.rate_x;
						rate_q[1] <= in_ch.rate_y;
						rate_q[2] <= in_ch.rate_z;
						ticks_q   <= in_ch.elapsed_ticks;
						pass_q    <= PASS_MAG_R;
						state_q   <= ST_CPASS;
					end
				end

				ST_CPASS: begin
					state_q     <= ST_CWAIT;
					cordic_go_q <= 1'b1;
					case (pass_q)
						PASS_MAG_R: begin
							cx_q <= abs_scaled(ay_q);
							cy_q <= scaled(az_q);
						end
						PASS_ONE_R: begin
							cx_q <= abs_scaled(ax_q);
							cy_q <= '0;
						end
						PASS_MAG_P: begin
							cx_q <= abs_scaled(ax_q);
							cy_q <= scaled(az_q);
						end
						PASS_ONE_P: begin
							cx_q <= abs_scaled(ay_q);
							cy_q <= '0;
						end
						default: begin
							cx_q <= m_q;
							cy_q <= s_q;
							// With all three axes at zero the angle is zero and
							// the pass is skipped.
							if (m_q == '0 && s_q == '0) begin
								cordic_go_q <= 1'b0;
								if (pass_q == PASS_ANG_R) begin
									zr_q    <= '0;
									pass_q  <= PASS_MAG_P;
									state_q <= ST_CPASS;
								end else begin
									zp_q    <= '0;
									op_q    <= OP_TILT_R;
									state_q <= ST_MPASS;
								end
							end
						end
					endcase
				end

				ST_CWAIT: begin
					if (c_stat.done) begin
						state_q <= ST_CPASS;
						pass_q  <= pass_t'(pass_q + 1'b1);
						case (pass_q)
							PASS_MAG_R, PASS_MAG_P: m_q <= c_x;
							PASS_ONE_R: s_q <= ax_q[15] ? -c_x : c_x;
							PASS_ONE_P: s_q <= ay_q[15] ? -c_x : c_x;
							PASS_ANG_R: zr_q <= c_z;
							default: begin
								zp_q    <= c_z;
								op_q    <= OP_TILT_R;
								state_q <= ST_MPASS;
							end
						endcase
					end
				end

				ST_MPASS: begin
					state_q        <= ST_MWAIT;
					mac_cmd_q.go   <= 1'b1;
					mac_cmd_q.keep <= 1'b0;
					case (op_q)
						OP_TILT_R: begin
							mac_init_q       <= TILT_ROUND;
							mac_a_q          <= acc_t'(zr_q);
							mac_b_q          <= {8'd0, tilt_gain_q};
							mac_cmd_q.digits <= dig_cnt_t'(6);
						end
						OP_TILT_P: begin
							mac_init_q       <= TILT_ROUND;
							mac_a_q          <= acc_t'(zp_q);
							mac_b_q          <= {8'd0, tilt_gain_q};
							mac_cmd_q.digits <= dig_cnt_t'(6);
						end
						OP_RT: begin
							mac_init_q       <= '0;
							mac_a_q          <= acc_t'(rate_q[axis_q]);
							mac_b_q          <= {16'd0, ticks_q};
							mac_cmd_q.digits <= dig_cnt_t'(4);
						end
						OP_PG: begin
							mac_init_q       <= '0;
							mac_a_q          <= prod_q;
							mac_b_q          <= gyro_gain_q;
							mac_cmd_q.digits <= dig_cnt_t'(8);
						end
						OP_BK: begin
							mac_init_q       <= BLEND_ROUND;
							mac_a_q          <= acc_t'(sum_q);
							mac_b_q          <= {16'd0, blend_q};
							mac_cmd_q.digits <= dig_cnt_t'(4);
						end
						default: begin
							// Second half of the blend adds (1 - k) * tilt onto
							// the running sum; yaw has no tilt.
							mac_cmd_q.keep   <= 1'b1;
							mac_init_q       <= '0;
							mac_a_q          <= (axis_q == AXIS_YAW) ? '0 :
							                    acc_t'(tilt_q[axis_q[0]]);
							mac_b_q          <= 32'(17'h10000 - {1'b0, blend_q});
							mac_cmd_q.digits <= dig_cnt_t'(5);
						end
					endcase
				end

				ST_MWAIT: begin
					if (m_stat.done) begin
						state_q <= ST_MPASS;
						case (op_q)
							OP_TILT_R: begin
								tilt_q[0] <= ang_t'(m_acc >>> 30);
								op_q      <= OP_TILT_P;
							end
							OP_TILT_P: begin
								tilt_q[1] <= ang_t'(m_acc >>> 30);
								axis_q    <= AXIS_ROLL;
								op_q      <= OP_RT;
							end
							OP_RT: begin
								prod_q <= m_acc;
								op_q   <= OP_PG;
							end
							OP_PG: begin
								sum_q <= sat32(acc_t'(angle_q[axis_q]) + (m_acc >>> 32));
								op_q  <= OP_BK;
							end
							OP_BK: begin
								op_q <= OP_BT;
							end
							default: begin
								angle_q[axis_q] <= sat32(m_acc >>> 16);
								res_q[axis_q]   <= sat32(m_acc >>> 16);
								if (axis_q == AXIS_YAW) begin
									state_q <= ST_OUT;
								end else begin
									axis_q <= axis_q + 1'b1;
									op_q   <= OP_RT;
								end
							end
						endcase
					end
				end

				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.roll_angle  = out_q[0];
	assign out_ch.pitch_angle = out_q[1];
	assign out_ch.yaw_angle   = out_q[2];

	// No item is taken while either arithmetic unit is still working.
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (!c_stat.busy && !m_stat.busy))
		else $error("item accepted while an arithmetic unit is busy");

	// A finished CORDIC pass is always awaited by the sequencer.
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		c_stat.done |-> (state_q == ST_CWAIT))
		else $error("CORDIC result arrived outside its wait state");

	// A finished multiply is always awaited by the sequencer.
	a_mac_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_stat.done |-> (state_q == ST_MWAIT))
		else $error("multiply result arrived outside its wait state");

	// A new result is only ever loaded from the output state.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output loaded outside the output state");

endmodule
